### hdl/cifd_pkg.sv
// Shared types and constants for the CAN id/mask acceptance filter.
// Used by cifd_ctrl, cifd_datapath, can_id_mask_filter_dispatch and the testbench; no dependencies.
package cifd_pkg;

	// Table geometry and field widths
	localparam int FILTER_SLOTS = 16;
	localparam int CLIENT_SLOTS = 16;
	localparam int ID_BITS      = 29;
	localparam int CLIENT_W     = 4;
	localparam int FORMAT_W     = 8;
	localparam int HITS_W       = 32;
	localparam int RC_W         = 5;
	localparam int IDX_W        = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
	localparam int CNT_W        = $clog2(FILTER_SLOTS + 1);

	// Input operation codes
	typedef enum logic [1:0] {
		MODE_FRAME  = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_REMOVE = 2'd2
	} mode_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_DELIVERED = 3'd0,
		ST_NO_MATCH  = 3'd1,
		ST_ADDED     = 3'd2,
		ST_FULL      = 3'd3,
		ST_REMOVED   = 3'd4
	} status_t;

	// One filter in the table
	typedef struct packed {
		logic [ID_BITS-1:0]  id;
		logic [ID_BITS-1:0]  mask;
		logic [CLIENT_W-1:0] owner;
		logic [FORMAT_W-1:0] format;
		logic [HITS_W-1:0]   hits;
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan_step;
		logic scan_end;
		logic add;
		logic purge_step;
		logic purge_end;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic at_end;
	} dp_stat_t;

endpackage

### hdl/cifd_ctrl.sv
// Sequencer for the acceptance filter: picks the operation and walks the table.
// Depends on cifd_pkg; drives cifd_datapath through ctl_cmd_t.
module cifd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          mode,
	input  cifd_pkg::dp_stat_t  stat,
	output cifd_pkg::ctl_cmd_t  cmd,
	output logic                busy
);
	import cifd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_ADD,
		S_PURGE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Commands decoded from the current state; load from an accepted start
	always_comb begin
		cmd            = '0;
		cmd.load       = accept;
		cmd.scan_step  = (state_q == S_SCAN)  && !stat.at_end;
		cmd.scan_end   = (state_q == S_SCAN)  &&  stat.at_end;
		cmd.add        = (state_q == S_ADD);
		cmd.purge_step = (state_q == S_PURGE) && !stat.at_end;
		cmd.purge_end  = (state_q == S_PURGE) &&  stat.at_end;
	end

	// State and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_FRAME: begin
								state_q <= S_SCAN;
								busy_q  <= 1'b1;
							end
							MODE_ADD: begin
								state_q <= S_ADD;
								busy_q  <= 1'b1;
							end
							MODE_REMOVE: begin
								state_q <= S_PURGE;
								busy_q  <= 1'b1;
							end
							default: begin
								// unused code: no result, stay idle
								state_q <= S_IDLE;
								busy_q  <= 1'b0;
							end
						endcase
					end
				end
				S_SCAN, S_PURGE: begin
					if (stat.at_end) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_ADD: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

### hdl/cifd_datapath.sv
// Filter table, match/compact logic and result register of the acceptance filter.
// Depends on cifd_pkg; steered by cifd_ctrl.
module cifd_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cifd_pkg::ctl_cmd_t             cmd,
	output cifd_pkg::dp_stat_t             stat,
	input  logic [cifd_pkg::ID_BITS-1:0]   frame_id,
	input  logic [cifd_pkg::ID_BITS-1:0]   match_id,
	input  logic [cifd_pkg::ID_BITS-1:0]   match_mask,
	input  logic [cifd_pkg::CLIENT_W-1:0]  client,
	input  logic [cifd_pkg::FORMAT_W-1:0]  format,
	output logic                           strobe,
	output logic [2:0]                     status,
	output logic [cifd_pkg::CLIENT_W-1:0]  dest_client,
	output logic [cifd_pkg::FORMAT_W-1:0]  dest_format,
	output logic [cifd_pkg::HITS_W-1:0]    hits,
	output logic [cifd_pkg::RC_W-1:0]      removed_count,
	output logic                           last
);
	import cifd_pkg::*;

	// Filter table, no reset: only entries below the count are read
	entry_t tbl_q [FILTER_SLOTS];

	// Latched operands of the current beat
	logic [ID_BITS-1:0]  frame_q;
	logic [ID_BITS-1:0]  id_q;
	logic [ID_BITS-1:0]  mask_q;
	logic [CLIENT_W-1:0] client_q;
	logic [FORMAT_W-1:0] format_q;

	// Walk state
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] keep_q;
	logic [CNT_W-1:0] removed_q;

	// Held delivery, sent once the next match or the end is seen
	logic                pend_valid_q;
	logic [CLIENT_W-1:0] pend_client_q;
	logic [FORMAT_W-1:0] pend_format_q;
	logic [HITS_W-1:0]   pend_hits_q;

	// Result register
	logic                strobe_q;
	status_t             status_q;
	logic [CLIENT_W-1:0] dclient_q;
	logic [FORMAT_W-1:0] dformat_q;
	logic [HITS_W-1:0]   hits_q;
	logic [RC_W-1:0]     rc_q;
	logic                last_q;

	entry_t              rd;
	logic                hit;
	logic [HITS_W-1:0]   hits_inc;
	logic                full;
	logic                bad_client;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;

	logic                emit;
	status_t             e_status;
	logic [CLIENT_W-1:0] e_client;
	logic [FORMAT_W-1:0] e_format;
	logic [HITS_W-1:0]   e_hits;
	logic [RC_W-1:0]     e_rc;
	logic                e_last;

	assign stat.at_end = (scan_q == count_q);

	// Read at the walk pointer, compare and bump the counter
	assign rd         = tbl_q[scan_q[IDX_W-1:0]];
	assign hit        = ((frame_q & rd.mask) == rd.id);
	assign hits_inc   = (rd.hits == {HITS_W{1'b1}}) ? rd.hits : rd.hits + 1'b1;
	assign full       = (count_q == CNT_W'(FILTER_SLOTS));
	assign bad_client = (32'(client_q) >= 32'(CLIENT_SLOTS));

	// Single table write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = scan_q[IDX_W-1:0];
		wr_data = rd;
		if (cmd.scan_step && hit) begin
			wr_en        = 1'b1;
			wr_data.hits = hits_inc;
		end else if (cmd.add && !full && !bad_client) begin
			wr_en          = 1'b1;
			wr_addr        = count_q[IDX_W-1:0];
			wr_data.id     = id_q;
			wr_data.mask   = mask_q;
			wr_data.owner  = client_q;
			wr_data.format = format_q;
			wr_data.hits   = '0;
		end else if (cmd.purge_step && (rd.owner != client_q)) begin
			wr_en   = 1'b1;
			wr_addr = keep_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_q[wr_addr] <= wr_data;
		end
	end

	// Result selection
	always_comb begin
		emit     = 1'b0;
		e_status = ST_NO_MATCH;
		e_client = '0;
		e_format = '0;
		e_hits   = '0;
		e_rc     = '0;
		e_last   = 1'b1;
		if (cmd.scan_step && hit && pend_valid_q) begin
			emit     = 1'b1;
			e_status = ST_DELIVERED;
			e_client = pend_client_q;
			e_format = pend_format_q;
			e_hits   = pend_hits_q;
			e_last   = 1'b0;
		end else if (cmd.scan_end) begin
			emit = 1'b1;
			if (pend_valid_q) begin
				e_status = ST_DELIVERED;
				e_client = pend_client_q;
				e_format = pend_format_q;
				e_hits   = pend_hits_q;
			end
		end else if (cmd.add) begin
			emit     = 1'b1;
			e_status = (full || bad_client) ? ST_FULL : ST_ADDED;
		end else if (cmd.purge_end) begin
			emit     = 1'b1;
			e_status = ST_REMOVED;
			e_rc     = RC_W'(removed_q);
		end
	end

	// Operand latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame_q  <= frame_id;
			id_q     <= match_id;
			mask_q   <= match_mask;
			client_q <= client;
			format_q <= format;
		end
	end

	// Walk pointers, count and held delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			scan_q       <= '0;
			keep_q       <= '0;
			removed_q    <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q       <= '0;
				keep_q       <= '0;
				removed_q    <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
				if (hit) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (cmd.scan_end) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.add && !full && !bad_client) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.purge_step) begin
				scan_q <= scan_q + 1'b1;
				if (rd.owner == client_q) begin
					removed_q <= removed_q + 1'b1;
				end else begin
					keep_q <= keep_q + 1'b1;
				end
			end
			if (cmd.purge_end) begin
				count_q <= keep_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && hit) begin
			pend_client_q <= rd.owner;
			pend_format_q <= rd.format;
			pend_hits_q   <= hits_inc;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= e_status;
			dclient_q <= e_client;
			dformat_q <= e_format;
			hits_q    <= e_hits;
			rc_q      <= e_rc;
			last_q    <= e_last;
		end
	end

	assign strobe        = strobe_q;
	assign status        = status_q;
	assign dest_client   = dclient_q;
	assign dest_format   = dformat_q;
	assign hits          = hits_q;
	assign removed_count = rc_q;
	assign last          = last_q;

endmodule

### hdl/can_id_mask_filter_dispatch.sv
// Top level of the CAN id/mask acceptance filter with client dispatch.
// Depends on cifd_pkg, cifd_ctrl and cifd_datapath.
//
// A beat is taken when start is high and busy is low. A received frame (mode 0)
// walks the filter table one slot per clock, and each match, in insertion order,
// is shown on the result ports for one cycle with strobe high; the final result
// of the beat has last set, and a frame that matches nothing gives one no-match
// result. An add (mode 1) appends one filter unless the table is full; a remove
// (mode 2) compacts the table and reports how many filters went. Mode 3 is
// ignored and gives no result. The table has a single write port. The receiver
// cannot stall: every result must be captured in the cycle its strobe is high.
module can_id_mask_filter_dispatch (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     mode,
	input  logic [cifd_pkg::ID_BITS-1:0]   frame_id,
	input  logic [cifd_pkg::ID_BITS-1:0]   match_id,
	input  logic [cifd_pkg::ID_BITS-1:0]   match_mask,
	input  logic [cifd_pkg::CLIENT_W-1:0]  client,
	input  logic [cifd_pkg::FORMAT_W-1:0]  format,
	output logic                           strobe,
	output logic [2:0]                     status,
	output logic [cifd_pkg::CLIENT_W-1:0]  dest_client,
	output logic [cifd_pkg::FORMAT_W-1:0]  dest_format,
	output logic [cifd_pkg::HITS_W-1:0]    hits,
	output logic [cifd_pkg::RC_W-1:0]      removed_count,
	output logic                           last
);
	import cifd_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	cifd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	cifd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.frame_id      (frame_id),
		.match_id      (match_id),
		.match_mask    (match_mask),
		.client        (client),
		.format        (format),
		.strobe        (strobe),
		.status        (status),
		.dest_client   (dest_client),
		.dest_format   (dest_format),
		.hits          (hits),
		.removed_count (removed_count),
		.last          (last)
	);

endmodule

### sim/testbench.sv
// Self-checking testbench for can_id_mask_filter_dispatch: directed and random beats
// against a behavioral model of the filter table. Depends on cifd_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import cifd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BEATS = 295;
	localparam int DRAIN_CYCLES = 2 * (FILTER_SLOTS + 2) + 4;
	localparam int MAX_PRINTS   = 50;

	localparam logic [1:0]         MODE_UNUSED = 2'd3;
	localparam logic [ID_BITS-1:0] ID_ALL      = '1;
	localparam logic [HITS_W-1:0]  HITS_MAX    = '1;

	// One expected result
	typedef struct packed {
		status_t             status;
		logic [CLIENT_W-1:0] dest_client;
		logic [FORMAT_W-1:0] dest_format;
		logic [HITS_W-1:0]   hits;
		logic [RC_W-1:0]     removed_count;
		logic                last;
	} dispatch_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          mode;
	logic [ID_BITS-1:0]  frame_id;
	logic [ID_BITS-1:0]  match_id;
	logic [ID_BITS-1:0]  match_mask;
	logic [CLIENT_W-1:0] client;
	logic [FORMAT_W-1:0] format;
	logic                strobe;
	logic [2:0]          status;
	logic [CLIENT_W-1:0] dest_client;
	logic [FORMAT_W-1:0] dest_format;
	logic [HITS_W-1:0]   hits;
	logic [RC_W-1:0]     removed_count;
	logic                last;

	can_id_mask_filter_dispatch dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.frame_id     (frame_id),
		.match_id     (match_id),
		.match_mask   (match_mask),
		.client       (client),
		.format       (format),
		.strobe       (strobe),
		.status       (status),
		.dest_client  (dest_client),
		.dest_format  (dest_format),
		.hits         (hits),
		.removed_count(removed_count),
		.last         (last)
	);

	// Shadow copy of the filter table
	logic [ID_BITS-1:0]  flt_id     [FILTER_SLOTS];
	logic [ID_BITS-1:0]  flt_mask   [FILTER_SLOTS];
	logic [CLIENT_W-1:0] flt_owner  [FILTER_SLOTS];
	logic [FORMAT_W-1:0] flt_format [FILTER_SLOTS];
	logic [HITS_W-1:0]   flt_hits   [FILTER_SLOTS];
	int                  flt_count;

	dispatch_t expected_dispatch[$];

	int mismatch_count;
	int cycle_count;
	int burst_left;
	int results_checked;
	int frames_sent, adds_sent, removes_sent, ignored_sent;
	int full_seen, nomatch_seen, most_matches;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Apply one accepted beat to the shadow table and queue its results
	task automatic predict_dispatch(input logic [1:0] md, input logic [ID_BITS-1:0] fid,
			input logic [ID_BITS-1:0] mid, input logic [ID_BITS-1:0] mmask,
			input logic [CLIENT_W-1:0] cl, input logic [FORMAT_W-1:0] fmt);
		dispatch_t r;
		dispatch_t found[$];
		int kept;
		int gone;
		r = '0;
		r.last = 1'b1;
		case (md)
			MODE_FRAME: begin
				frames_sent++;
				for (int i = 0; i < flt_count; i++) begin
					if ((fid & flt_mask[i]) == flt_id[i]) begin
						// counter saturates at all ones
						if (flt_hits[i] != HITS_MAX)
							flt_hits[i]++;
						r.status      = ST_DELIVERED;
						r.dest_client = flt_owner[i];
						r.dest_format = flt_format[i];
						r.hits        = flt_hits[i];
						r.last        = 1'b0;
						found.push_back(r);
					end
				end
				if (found.size() == 0) begin
					nomatch_seen++;
					r.status = ST_NO_MATCH;
					r.last   = 1'b1;
					found.push_back(r);
				end else begin
					found[found.size()-1].last = 1'b1;
				end
				if (found.size() > most_matches)
					most_matches = found.size();
				foreach (found[k])
					expected_dispatch.push_back(found[k]);
			end
			MODE_ADD: begin
				adds_sent++;
				if (flt_count >= FILTER_SLOTS || int'(cl) >= CLIENT_SLOTS) begin
					full_seen++;
					r.status = ST_FULL;
				end else begin
					flt_id[flt_count]     = mid;
					flt_mask[flt_count]   = mmask;
					flt_owner[flt_count]  = cl;
					flt_format[flt_count] = fmt;
					flt_hits[flt_count]   = '0;
					flt_count++;
					r.status = ST_ADDED;
				end
				expected_dispatch.push_back(r);
			end
			MODE_REMOVE: begin
				removes_sent++;
				kept = 0;
				gone = 0;
				// drop the client's filters, keep the rest in order
				for (int i = 0; i < flt_count; i++) begin
					if (flt_owner[i] == cl) begin
						gone++;
					end else begin
						flt_id[kept]     = flt_id[i];
						flt_mask[kept]   = flt_mask[i];
						flt_owner[kept]  = flt_owner[i];
						flt_format[kept] = flt_format[i];
						flt_hits[kept]   = flt_hits[i];
						kept++;
					end
				end
				flt_count = kept;
				r.status        = ST_REMOVED;
				r.removed_count = RC_W'(gone);
				expected_dispatch.push_back(r);
			end
			default: ignored_sent++;
		endcase
	endtask

	// Drive one beat, with a random gap between bursts, and wait for acceptance
	task automatic send_beat(input logic [1:0] md, input logic [ID_BITS-1:0] fid,
			input logic [ID_BITS-1:0] mid, input logic [ID_BITS-1:0] mmask,
			input logic [CLIENT_W-1:0] cl, input logic [FORMAT_W-1:0] fmt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		burst_left--;
		start      <= 1'b1;
		mode       <= md;
		frame_id   <= fid;
		match_id   <= mid;
		match_mask <= mmask;
		client     <= cl;
		format     <= fmt;
		do @(posedge clk); while (busy !== 1'b0);
		predict_dispatch(md, fid, mid, mmask, cl, fmt);
	endtask

	// Compare every strobed result with the oldest expectation
	always @(posedge clk) begin
		dispatch_t want;
		if (arst_n && strobe === 1'b1) begin
			if (expected_dispatch.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d", status));
			end else begin
				want = expected_dispatch.pop_front();
				results_checked++;
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %s",
						status, want.status.name()));
				if (dest_client !== want.dest_client)
					report_mismatch($sformatf("dest_client %0d, want %0d",
						dest_client, want.dest_client));
				if (dest_format !== want.dest_format)
					report_mismatch($sformatf("dest_format %02h, want %02h",
						dest_format, want.dest_format));
				if (hits !== want.hits)
					report_mismatch($sformatf("hits %0d, want %0d", hits, want.hits));
				if (removed_count !== want.removed_count)
					report_mismatch($sformatf("removed_count %0d, want %0d",
						removed_count, want.removed_count));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b", last, want.last));
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_dispatch.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// A frame and a remove on an empty table, plus the unused mode
	task automatic test_empty_table();
		send_beat(MODE_FRAME, ID_ALL, '0, '0, 4'd0, 8'd0);
		send_beat(MODE_REMOVE, '0, '0, '0, 4'd5, 8'd0);
		send_beat(MODE_UNUSED, ID_ALL, ID_ALL, ID_ALL, 4'd15, 8'hff);
	endtask

	// Matches come out in insertion order; removal compacts
	task automatic test_match_order();
		send_beat(MODE_ADD, '0, '0, '0, 4'd0, 8'h00);
		send_beat(MODE_ADD, '0, ID_ALL, ID_ALL, 4'd15, 8'hff);
		send_beat(MODE_ADD, '0, 29'h155, 29'h7ff, 4'd3, 8'ha5);
		send_beat(MODE_FRAME, ID_ALL, '0, '0, 4'd0, 8'd0);
		send_beat(MODE_FRAME, 29'h155, '0, '0, 4'd0, 8'd0);
		send_beat(MODE_REMOVE, '0, '0, '0, 4'd0, 8'd0);
		send_beat(MODE_FRAME, '0, '0, '0, 4'd0, 8'd0);
	endtask

	// Fill the table, overflow it, hit every added filter, then clear the fill
	task automatic test_table_full();
		int k;
		k = 0;
		while (flt_count < FILTER_SLOTS) begin
			send_beat(MODE_ADD, '0, '0, '0, 4'd9, FORMAT_W'(k));
			k++;
		end
		send_beat(MODE_ADD, '0, 29'h1, ID_ALL, 4'd1, 8'h5a);
		send_beat(MODE_FRAME, ID_ALL, '0, '0, 4'd0, 8'd0);
		send_beat(MODE_REMOVE, '0, '0, '0, 4'd9, 8'd0);
	endtask

	// Mixed traffic: frames mostly aimed at stored filters
	task automatic test_random_traffic();
		int counted;
		int sel;
		int j;
		logic [1:0]          md;
		logic [ID_BITS-1:0]  fid, mid, mmask, noise;
		logic [CLIENT_W-1:0] cl;
		logic [FORMAT_W-1:0] fmt;
		counted = 0;
		while (counted < RANDOM_BEATS) begin
			sel   = $urandom_range(0, 99);
			fid   = ID_BITS'($urandom);
			mid   = ID_BITS'($urandom);
			noise = ID_BITS'($urandom);
			fmt   = FORMAT_W'($urandom);
			cl    = ($urandom_range(0, 9) < 7) ? CLIENT_W'($urandom_range(0, 3))
				: CLIENT_W'($urandom_range(0, 15));
			sel = (flt_count < 3 && sel >= 5) ? 50 : sel;
			// mask shapes: none, full, random, sparse
			case ($urandom_range(0, 19))
				0, 1:       mmask = '0;
				2, 3, 4:    mmask = ID_ALL;
				5, 6, 7, 8,
				9, 10, 11:  mmask = ID_BITS'($urandom);
				default:    mmask = ID_BITS'($urandom & $urandom & $urandom);
			endcase
			if (sel < 5) begin
				md = MODE_UNUSED;
			end else if (sel < 50) begin
				md = MODE_FRAME;
				if (flt_count > 0 && $urandom_range(0, 9) < 7) begin
					j   = $urandom_range(0, flt_count - 1);
					fid = (flt_id[j] & flt_mask[j]) | (noise & ~flt_mask[j]);
				end
			end else if (sel < 80) begin
				md = MODE_ADD;
				if ($urandom_range(0, 3) != 0)
					mid = mid & mmask;
			end else begin
				md = MODE_REMOVE;
				if (flt_count > 0 && $urandom_range(0, 3) != 0)
					cl = flt_owner[$urandom_range(0, flt_count - 1)];
			end
			send_beat(md, fid, mid, mmask, cl, fmt);
			if (md != MODE_UNUSED)
				counted++;
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		mode       <= MODE_FRAME;
		frame_id   <= '0;
		match_id   <= '0;
		match_mask <= '0;
		client     <= '0;
		format     <= '0;
		flt_count       = 0;
		burst_left      = 0;
		mismatch_count  = 0;
		cycle_count     = 0;
		results_checked = 0;
		frames_sent     = 0;
		adds_sent       = 0;
		removes_sent    = 0;
		ignored_sent    = 0;
		full_seen       = 0;
		nomatch_seen    = 0;
		most_matches    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_match_order();
		test_table_full();
		test_random_traffic();

		// drain outstanding results, then let the block settle
		start <= 1'b0;
		while (expected_dispatch.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d frames, %0d adds (%0d refused as full), %0d removes, %0d ignored",
			frames_sent, adds_sent, full_seen, removes_sent, ignored_sent);
		$display("Checked %0d results: %0d no-match, up to %0d deliveries per frame",
			results_checked, nomatch_seen, most_matches);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/cifd_pkg.sv
hdl/cifd_ctrl.sv
hdl/cifd_datapath.sv
hdl/can_id_mask_filter_dispatch.sv
sim/testbench.sv
